[rtl/encoder_pid_speed_control_unit_macros.svh]
// assertion helpers for the speed control block
// expects clk and rst_n in the scope of use
`ifndef ENCODER_PID_SPEED_CONTROL_UNIT_MACROS_SVH
`define ENCODER_PID_SPEED_CONTROL_UNIT_MACROS_SVH

// same-cycle implication
`define EPSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("speed control check failed");

// next-cycle implication
`define EPSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("speed control check failed");

`endif

[rtl/epsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package epsc_pkg;

  // default values of the top level parameters
  localparam int FRAC_BITS_DEF      = 8;
  localparam int PULSE_MAX_DEF      = 20000;
  localparam int INTEGRAL_WIDTH_DEF = 32;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // integral is split into two chunks for the gain product
  localparam int INT_SPLIT = 24;
  localparam int INT_EXT_W = 2 * INT_SPLIT;
  localparam int ACC_W     = MUL_P_W + INT_SPLIT + 1;

  // x / 10 for x below 2^16 as (x * 52429) >> 19
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;

  // register map, index = paddr / 4
  localparam logic [2:0] REG_KP     = 3'd0;
  localparam logic [2:0] REG_KI     = 3'd1;
  localparam logic [2:0] REG_KD     = 3'd2;
  localparam logic [2:0] REG_TARGET = 3'd3;
  localparam logic [2:0] REG_CTS    = 3'd4;
  localparam logic [2:0] REG_BASE   = 3'd5;
  localparam logic [2:0] REG_STOP   = 3'd6;
  localparam logic [2:0] REG_WRAP   = 3'd7;

  localparam logic [15:0] KP_RST     = 16'd2560;
  localparam logic [15:0] KI_RST     = 16'd1280;
  localparam logic [15:0] KD_RST     = 16'd1280;
  localparam logic [15:0] TARGET_RST = 16'd128;
  localparam logic [15:0] CTS_RST    = 16'd51;
  localparam logic [14:0] BASE_RST   = 15'd1550;
  localparam logic [14:0] STOP_RST   = 15'd1400;
  localparam logic [8:0]  WRAP_RST   = 9'd100;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [15:0] kd_gain;
    logic [15:0] target_speed;
    logic [15:0] count_to_speed;
    logic [14:0] base_pulse;
    logic [14:0] stop_pulse;
    logic [8:0]  count_wrap;
  } epsc_cfg_t;

endpackage
`default_nettype wire

[rtl/epsc_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
module epsc_regs import epsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output epsc_cfg_t        cfg
);

  epsc_cfg_t  cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain        <= KP_RST;
      cfg_r.ki_gain        <= KI_RST;
      cfg_r.kd_gain        <= KD_RST;
      cfg_r.target_speed   <= TARGET_RST;
      cfg_r.count_to_speed <= CTS_RST;
      cfg_r.base_pulse     <= BASE_RST;
      cfg_r.stop_pulse     <= STOP_RST;
      cfg_r.count_wrap     <= WRAP_RST;
    end else if (wr_en) begin
      case (idx)
        REG_KP:     cfg_r.kp_gain        <= pwdata[15:0];
        REG_KI:     cfg_r.ki_gain        <= pwdata[15:0];
        REG_KD:     cfg_r.kd_gain        <= pwdata[15:0];
        REG_TARGET: cfg_r.target_speed   <= pwdata[15:0];
        REG_CTS:    cfg_r.count_to_speed <= pwdata[15:0];
        REG_BASE:   cfg_r.base_pulse     <= pwdata[14:0];
        REG_STOP:   cfg_r.stop_pulse     <= pwdata[14:0];
        REG_WRAP:   cfg_r.count_wrap     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KP:     prdata = {16'd0, cfg_r.kp_gain};
      REG_KI:     prdata = {16'd0, cfg_r.ki_gain};
      REG_KD:     prdata = {16'd0, cfg_r.kd_gain};
      REG_TARGET: prdata = {16'd0, cfg_r.target_speed};
      REG_CTS:    prdata = {16'd0, cfg_r.count_to_speed};
      REG_BASE:   prdata = {17'd0, cfg_r.base_pulse};
      REG_STOP:   prdata = {17'd0, cfg_r.stop_pulse};
      REG_WRAP:   prdata = {23'd0, cfg_r.count_wrap};
      default:    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/epsc_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
module epsc_mul import epsc_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [MUL_A_W-1:0]  a,
  input  wire logic signed [MUL_B_W-1:0]  b,
  output logic signed      [MUL_P_W-1:0]  prod_r
);

  logic signed [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = MUL_P_W'(a) * MUL_P_W'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/encoder_pid_speed_control_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake            payload
// in        input      in_valid / in_stall   in_pulse_count, in_stop_request
// out       output     out_valid / out_stall out_pulse_width_us, out_correction_us,
//                                            out_measured_speed, out_stopped
// cfg       apb        psel/penable/pready   paddr, pwdata, prdata
//
// the sequencer steps through six products on the single 25x17 multiplier before the result
// is loaded into the output register; a new item is taken only after the last one is loaded
// in_stall stays high from accept until the result is loaded into the output register
// a stalled result holds the sequencer in its last step; the next item is taken
// while a loaded result still waits on out_stall
// rst_n is synchronous: clears the pid state and the output valid, and sets the registers to their reset values
module encoder_pid_speed_control_unit import epsc_pkg::*; #(
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  parameter int PULSE_MAX      = PULSE_MAX_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_pulse_count,
  input  wire logic        in_stop_request,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [14:0] out_pulse_width_us,
  output logic signed [15:0] out_correction_us,
  output logic      [15:0] out_measured_speed,
  output logic             out_stopped,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int IW = INTEGRAL_WIDTH;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SPD  = 4'd1;
  localparam logic [3:0] S_ERR  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_KP   = 4'd4;
  localparam logic [3:0] S_KD   = 4'd5;
  localparam logic [3:0] S_KIL  = 4'd6;
  localparam logic [3:0] S_KIH  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic signed [17:0]    PMAX_S   = 18'(PULSE_MAX);
  localparam logic signed [ACC_W-1:0] CORR_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] CORR_LO = ACC_W'(-32768);

  epsc_cfg_t cfg;

  epsc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [3:0]                state_r, state_nxt;
  logic [7:0]                last_count_r;
  logic signed [IW-1:0]      integral_r;
  logic signed [17:0]        last_err_r;
  logic signed [10:0]        delta_r;
  logic                      stop_r;
  logic [15:0]               speed_r;
  logic signed [17:0]        err_r;
  logic [15:0]               errmag_r;
  logic signed [22:0]        deriv_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      out_valid_r;
  logic [14:0]               out_pulse_r;
  logic signed [15:0]        out_corr_r;
  logic [15:0]               out_speed_r;
  logic                      out_stopped_r;

  logic                      accept;
  logic                      load_out;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod_r;

  logic signed [10:0]        delta_nxt;
  logic [15:0]               speed_c;
  logic signed [17:0]        err_c;
  logic signed [18:0]        diff_c;
  logic signed [22:0]        dd_c;
  logic signed [17:0]        negerr_c;
  logic [15:0]               q_c;
  logic signed [16:0]        qs_c;
  logic signed [IW:0]        isum_c;
  logic signed [IW-1:0]      integral_nxt;
  logic signed [INT_EXT_W-1:0] int_ext;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   shifted_c;
  logic signed [15:0]        corr_c;
  logic signed [17:0]        psum_c;
  logic signed [17:0]        stop_s;
  logic [14:0]               pulse_c;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign load_out = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // counter delta, wrapping at count_wrap
  always_comb begin
    if (in_pulse_count >= last_count_r) begin
      delta_nxt = $signed({3'b0, in_pulse_count}) - $signed({3'b0, last_count_r});
    end else begin
      delta_nxt = $signed({2'b0, cfg.count_wrap}) - $signed({3'b0, last_count_r})
                + $signed({3'b0, in_pulse_count});
    end
  end

  // speed saturation and error terms
  always_comb begin
    if (prod_r < 0) begin
      speed_c = 16'd0;
    end else if (prod_r > MUL_P_W'(65535)) begin
      speed_c = 16'hFFFF;
    end else begin
      speed_c = prod_r[15:0];
    end
    err_c    = $signed({2'b0, cfg.target_speed}) - $signed({2'b0, speed_c});
    negerr_c = -err_c;
    diff_c   = 19'(err_c) - 19'(last_err_r);
    dd_c     = 23'(diff_c);
  end

  // truncating divide by ten and saturating integral update
  always_comb begin
    q_c    = prod_r[DIV10_SHIFT+15:DIV10_SHIFT];
    qs_c   = err_r[17] ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
    isum_c = (IW+1)'(integral_r) + (IW+1)'(qs_c);
    if (isum_c[IW] != isum_c[IW-1]) begin
      integral_nxt = isum_c[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      integral_nxt = isum_c[IW-1:0];
    end
  end

  assign int_ext  = INT_EXT_W'(integral_r);
  assign prod_ext = ACC_W'(prod_r);

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_SPD: begin
        mul_a = MUL_A_W'(delta_r);
        mul_b = $signed({1'b0, cfg.count_to_speed});
      end
      S_DIV: begin
        mul_a = $signed({{(MUL_A_W-16){1'b0}}, errmag_r});
        mul_b = MUL_B_W'(DIV10_MUL);
      end
      S_KP: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = $signed({1'b0, cfg.kp_gain});
      end
      S_KD: begin
        mul_a = MUL_A_W'(deriv_r);
        mul_b = $signed({1'b0, cfg.kd_gain});
      end
      S_KIL: begin
        mul_a = $signed({1'b0, int_ext[INT_SPLIT-1:0]});
        mul_b = $signed({1'b0, cfg.ki_gain});
      end
      S_KIH: begin
        mul_a = MUL_A_W'($signed(int_ext[INT_EXT_W-1:INT_SPLIT]));
        mul_b = $signed({1'b0, cfg.ki_gain});
      end
      default: mul_en = 1'b0;
    endcase
  end

  epsc_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // floor of the q(2f) sum, saturated to 16 bits, then pulse saturation or the stop pulse
  always_comb begin
    shifted_c = acc_r >>> (2 * FRAC_BITS);
    if (shifted_c > CORR_HI) begin
      corr_c = 16'sh7FFF;
    end else if (shifted_c < CORR_LO) begin
      corr_c = -16'sh8000;
    end else begin
      corr_c = shifted_c[15:0];
    end
    psum_c = $signed({3'b0, cfg.base_pulse}) + 18'(corr_c);
    stop_s = $signed({3'b0, cfg.stop_pulse});
    if (stop_r) begin
      pulse_c = (stop_s > PMAX_S) ? PMAX_S[14:0] : stop_s[14:0];
    end else if (psum_c < 0) begin
      pulse_c = 15'd0;
    end else if (psum_c > PMAX_S) begin
      pulse_c = PMAX_S[14:0];
    end else begin
      pulse_c = psum_c[14:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SPD;
      S_SPD:   state_nxt = S_ERR;
      S_ERR:   state_nxt = S_DIV;
      S_DIV:   state_nxt = S_KP;
      S_KP:    state_nxt = S_KD;
      S_KD:    state_nxt = S_KIL;
      S_KIL:   state_nxt = S_KIH;
      S_KIH:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_count_r <= 8'd0;
      integral_r   <= '0;
      last_err_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        last_count_r <= in_pulse_count;
      end
      if (state_r == S_ERR) begin
        last_err_r <= err_c;
      end
      if (state_r == S_KP) begin
        integral_r <= integral_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      delta_r <= delta_nxt;
      stop_r  <= in_stop_request;
    end
    if (state_r == S_ERR) begin
      speed_r  <= speed_c;
      err_r    <= err_c;
      errmag_r <= err_c[17] ? negerr_c[15:0] : err_c[15:0];
      deriv_r  <= (dd_c <<< 3) + (dd_c <<< 1);
    end
    case (state_r)
      S_KD:    acc_r <= prod_ext;
      S_KIL:   acc_r <= acc_r + prod_ext;
      S_KIH:   acc_r <= acc_r + prod_ext;
      S_FIN:   acc_r <= acc_r + (prod_ext <<< INT_SPLIT);
      default: ;
    endcase
    if (load_out) begin
      out_pulse_r   <= pulse_c;
      out_corr_r    <= corr_c;
      out_speed_r   <= speed_r;
      out_stopped_r <= stop_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pulse_width_us = out_pulse_r;
  assign out_correction_us  = out_corr_r;
  assign out_measured_speed = out_speed_r;
  assign out_stopped        = out_stopped_r;

`include "encoder_pid_speed_control_unit_macros.svh"

  `EPSC_ASSERT_NEXT(a_accept_starts, accept, state_r == S_SPD)
  `EPSC_ASSERT_NOW(a_valid_from_out, $rose(out_valid_r), $past(state_r) == S_OUT)
  `EPSC_ASSERT_NEXT(a_out_hold, (state_r == S_OUT) && out_valid_r && out_stall,
                    state_r == S_OUT)

endmodule
`default_nettype wire
